>>> rtl/core/displacement_angle_degrees_unit_defines.svh
// assertion macros shared by the displacement angle unit
// depends on nothing; included by the modules that carry checks
`ifndef DISPLACEMENT_ANGLE_DEGREES_UNIT_DEFINES_SVH
`define DISPLACEMENT_ANGLE_DEGREES_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// check held while out of reset
`define DAD_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// check held on every edge, reset included
`define DAD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DAD_ASSERT(lbl, clk, rstn, prop, msg)
`define DAD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

>>> rtl/core/dad_pkg.sv
// shared types, constants and the arctangent table of the displacement angle unit
// depends on nothing
package dad_pkg;

  // parameter defaults
  localparam int COORD_BITS_DEF = 12;
  localparam int ITERATIONS_DEF = 18;

  // fixed-point widths
  localparam int SCALED_BITS = 32;  // folded components scaled to 32 bits
  localparam int XY_BITS     = 35;  // cordic x/y, signed, room for the cordic gain on a diagonal
  localparam int Z_BITS      = 25;  // accumulated angle, signed q.16 degrees
  localparam int TOTAL_BITS  = 26;  // rebuilt angle, unsigned q.16 degrees
  localparam int FRAC_BITS   = 16;
  localparam int DEG_BITS    = 9;
  localparam int QUEUE_DEPTH = 4;

  // angles in q.16 degrees
  localparam logic [TOTAL_BITS-1:0] ANG_45  = TOTAL_BITS'(45 * 65536);
  localparam logic [TOTAL_BITS-1:0] ANG_90  = TOTAL_BITS'(90 * 65536);
  localparam logic [TOTAL_BITS-1:0] ANG_180 = TOTAL_BITS'(180 * 65536);
  localparam logic [TOTAL_BITS-1:0] ANG_360 = TOTAL_BITS'(360 * 65536);

  // whole-degree limits
  localparam logic [TOTAL_BITS-FRAC_BITS-1:0] DEG_FULL = 10'd360;
  localparam logic [DEG_BITS-1:0]             DEG_MAX  = 9'd359;

  // how the first-quadrant angle is formed
  typedef enum logic [2:0] {
    CLS_ZERO,    // no displacement
    CLS_AXIS_X,  // along x
    CLS_DIAG,    // equal magnitudes
    CLS_LOW,     // below the diagonal, angle from cordic
    CLS_AXIS_Y,  // along y
    CLS_HIGH     // above the diagonal, 90 minus cordic angle
  } cls_t;

  // one queued transaction
  typedef struct packed {
    logic [SCALED_BITS-1:0] fx;
    logic [SCALED_BITS-1:0] fy;
    cls_t                   cls;
    logic                   dx_neg;
    logic                   dy_neg;
  } item_t;

  // atan(2^-i) in degrees times 65536, rounded
  function automatic logic [22:0] atan_q16(input int unsigned i);
    logic [22:0] v;
    case (i)
      0:  v = 23'd2949120;
      1:  v = 23'd1740967;
      2:  v = 23'd919879;
      3:  v = 23'd466945;
      4:  v = 23'd234379;
      5:  v = 23'd117304;
      6:  v = 23'd58666;
      7:  v = 23'd29335;
      8:  v = 23'd14668;
      9:  v = 23'd7334;
      10: v = 23'd3667;
      11: v = 23'd1833;
      12: v = 23'd917;
      13: v = 23'd458;
      14: v = 23'd229;
      15: v = 23'd115;
      16: v = 23'd57;
      17: v = 23'd29;
      18: v = 23'd14;
      19: v = 23'd7;
      20: v = 23'd4;
      21: v = 23'd2;
      22: v = 23'd1;
      default: v = 23'd0;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/core/displacement_angle_degrees_unit.sv
// top level of the displacement angle unit: front end, queue and cordic back end
// depends on dad_pkg, dad_front, dad_queue and dad_back
//
// Gives the direction of the displacement from (start_x, start_y) to (end_x, end_y)
// as whole degrees 0..359, counter-clockwise from +x, floored; a zero displacement
// gives 0 and anything that would reach 360 reads 359. The unit takes one
// transaction per clock while the output is not held and returns one result
// per transaction in order. A transaction passes through the queue, the load
// stage, one register per cordic stage and the result register. Throughput is set
// by the fully pipelined cordic, one micro-rotation per stage; when the output is
// held the pipe stops and the four-entry queue absorbs new transactions before
// in_ready drops.
module displacement_angle_degrees_unit #(
  parameter int COORD_BITS = dad_pkg::COORD_BITS_DEF,
  parameter int ITERATIONS = dad_pkg::ITERATIONS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [COORD_BITS-1:0]        in_start_x,
  input  logic [COORD_BITS-1:0]        in_start_y,
  input  logic [COORD_BITS-1:0]        in_end_x,
  input  logic [COORD_BITS-1:0]        in_end_y,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [dad_pkg::DEG_BITS-1:0] out_angle_deg
);

  dad_pkg::item_t front_item;
  dad_pkg::item_t q_item;
  logic           q_valid, q_ready;

  // classify and fold each incoming transaction
  dad_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .start_x (in_start_x),
    .start_y (in_start_y),
    .end_x   (in_end_x),
    .end_y   (in_end_y),
    .item    (front_item)
  );

  // decoupling queue
  dad_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_valid),
    .push_ready (in_ready),
    .push_item  (front_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item)
  );

  // cordic pipeline and result register
  dad_back #(
    .ITERATIONS (ITERATIONS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_ready       (q_ready),
    .q_item        (q_item),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_angle_deg (out_angle_deg)
  );

endmodule

>>> rtl/core/dad_front.sv
// front end: displacement, octant folding and classification of each transaction
// depends on dad_pkg
module dad_front #(
  parameter int COORD_BITS = dad_pkg::COORD_BITS_DEF
) (
  input  logic [COORD_BITS-1:0] start_x,
  input  logic [COORD_BITS-1:0] start_y,
  input  logic [COORD_BITS-1:0] end_x,
  input  logic [COORD_BITS-1:0] end_y,
  output dad_pkg::item_t        item
);

  localparam int SCALE = dad_pkg::SCALED_BITS - COORD_BITS;

  logic signed [COORD_BITS:0]      dx, dy;
  logic                            dx_neg, dy_neg;
  logic [COORD_BITS-1:0]           ax, ay;
  logic [dad_pkg::SCALED_BITS-1:0] sax, say;
  logic                            lo;

  // signed displacement and magnitudes
  assign dx     = $signed({1'b0, end_x}) - $signed({1'b0, start_x});
  assign dy     = $signed({1'b0, end_y}) - $signed({1'b0, start_y});
  assign dx_neg = dx[COORD_BITS];
  assign dy_neg = dy[COORD_BITS];
  assign ax     = dx_neg ? COORD_BITS'(-dx) : COORD_BITS'(dx);
  assign ay     = dy_neg ? COORD_BITS'(-dy) : COORD_BITS'(dy);

  // scale up to full cordic precision
  assign sax = {ax, {SCALE{1'b0}}};
  assign say = {ay, {SCALE{1'b0}}};
  assign lo  = (ay < ax);

  // fold into the first octant and classify
  always_comb begin
    item.fx     = lo ? sax : say;
    item.fy     = lo ? say : sax;
    item.dx_neg = dx_neg;
    item.dy_neg = dy_neg;
    if (ax == '0 && ay == '0) begin
      item.cls = dad_pkg::CLS_ZERO;
    end else if (ay == '0) begin
      item.cls = dad_pkg::CLS_AXIS_X;
    end else if (ax == ay) begin
      item.cls = dad_pkg::CLS_DIAG;
    end else if (lo) begin
      item.cls = dad_pkg::CLS_LOW;
    end else if (ax == '0) begin
      item.cls = dad_pkg::CLS_AXIS_Y;
    end else begin
      item.cls = dad_pkg::CLS_HIGH;
    end
  end

endmodule

>>> rtl/core/dad_queue.sv
// short shifting queue between the front end and the cordic back end
// depends on dad_pkg and the assertion macro header
`include "displacement_angle_degrees_unit_defines.svh"
module dad_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  dad_pkg::item_t push_item,
  output logic           pop_valid,
  input  logic           pop_ready,
  output dad_pkg::item_t pop_item
);

  localparam int DEPTH = dad_pkg::QUEUE_DEPTH;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int IW    = $clog2(DEPTH);

  dad_pkg::item_t slot_r   [DEPTH];
  dad_pkg::item_t slot_nxt [DEPTH];
  logic [CW-1:0]  count_r, count_nxt;
  logic [CW-1:0]  widx;
  logic           push, pop;

  // handshakes; the head always sits in slot zero
  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = slot_r[0];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign widx       = count_r - CW'(pop);

  // shift on pop, write behind the last live entry on push
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      slot_nxt[i] = slot_r[i];
    end
    if (pop) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        slot_nxt[i] = slot_r[i + 1];
      end
    end
    if (push) begin
      slot_nxt[widx[IW-1:0]] = push_item;
    end
    count_nxt = count_r + CW'(push) - CW'(pop);
  end

  // occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // entries
  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      slot_r[i] <= slot_nxt[i];
    end
  end

  `DAD_ASSERT(a_q_count_bound, clk, rst_n, count_r <= CW'(DEPTH), "queue count over depth")
  `DAD_ASSERT(a_q_grow, clk, rst_n, push && !pop |=> count_r == $past(count_r) + CW'(1), "queue did not grow")
  `DAD_ASSERT(a_q_shrink, clk, rst_n, pop && !push |=> count_r == $past(count_r) - CW'(1), "queue did not shrink")
  `DAD_ASSERT(a_q_head_hold, clk, rst_n, pop_valid && !pop_ready |=> $stable(pop_item), "queue head moved without pop")

endmodule

>>> rtl/core/dad_back.sv
// back end: pipelined vectoring cordic, quadrant rebuild and result register
// depends on dad_pkg and the assertion macro header
`include "displacement_angle_degrees_unit_defines.svh"
module dad_back #(
  parameter int ITERATIONS = dad_pkg::ITERATIONS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_valid,
  output logic                         q_ready,
  input  dad_pkg::item_t               q_item,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [dad_pkg::DEG_BITS-1:0] out_angle_deg
);

  localparam int XW = dad_pkg::XY_BITS;
  localparam int ZW = dad_pkg::Z_BITS;
  localparam int TW = dad_pkg::TOTAL_BITS;
  localparam int N  = ITERATIONS;

  logic [N:0]            v_r;
  logic signed [XW-1:0]  x_r   [N+1];
  logic signed [XW-1:0]  y_r   [N+1];
  logic signed [ZW-1:0]  z_r   [N+1];
  dad_pkg::cls_t         cls_r [N+1];
  logic                  dxn_r [N+1];
  logic                  dyn_r [N+1];
  logic signed [XW-1:0]  x_nxt [N];
  logic signed [XW-1:0]  y_nxt [N];
  logic signed [ZW-1:0]  z_nxt [N];

  logic                        adv;
  logic                        out_valid_r;
  logic [dad_pkg::DEG_BITS-1:0] angle_r, angle_nxt;
  logic [TW-1:0]               zc, a_w, total;
  logic [TW-dad_pkg::FRAC_BITS-1:0] deg_w;

  // whole pipe moves together unless the result register is held
  assign adv       = !out_valid_r || out_ready;
  assign q_ready   = adv;
  assign out_valid = out_valid_r;
  assign out_angle_deg = angle_r;

  // one micro-rotation per stage
  for (genvar k = 0; k < N; k++) begin : g_stage
    localparam logic signed [ZW-1:0] ATAN_K = ZW'(dad_pkg::atan_q16(k));
    logic signed [XW-1:0] xs, ymag, ysh, ys;
    always_comb begin
      xs   = x_r[k] >>> k;
      ymag = y_r[k][XW-1] ? -y_r[k] : y_r[k];
      ysh  = ymag >> k;
      ys   = y_r[k][XW-1] ? -ysh : ysh;
      if (!y_r[k][XW-1]) begin
        x_nxt[k] = x_r[k] + ys;
        y_nxt[k] = y_r[k] - xs;
        z_nxt[k] = z_r[k] + ATAN_K;
      end else begin
        x_nxt[k] = x_r[k] - ys;
        y_nxt[k] = y_r[k] + xs;
        z_nxt[k] = z_r[k] - ATAN_K;
      end
    end
  end

  // clamp the octant angle and rebuild the full direction
  always_comb begin
    if (z_r[N][ZW-1]) begin
      zc = '0;
    end else if (TW'(z_r[N]) > dad_pkg::ANG_45) begin
      zc = dad_pkg::ANG_45;
    end else begin
      zc = TW'(z_r[N]);
    end
    case (cls_r[N])
      dad_pkg::CLS_DIAG:   a_w = dad_pkg::ANG_45;
      dad_pkg::CLS_LOW:    a_w = zc;
      dad_pkg::CLS_AXIS_Y: a_w = dad_pkg::ANG_90;
      dad_pkg::CLS_HIGH:   a_w = dad_pkg::ANG_90 - zc;
      default:             a_w = '0;
    endcase
    if (!dxn_r[N] && !dyn_r[N]) begin
      total = a_w;
    end else if (dxn_r[N] && !dyn_r[N]) begin
      total = dad_pkg::ANG_180 - a_w;
    end else if (dxn_r[N]) begin
      total = dad_pkg::ANG_180 + a_w;
    end else begin
      total = dad_pkg::ANG_360 - a_w;
    end
    deg_w = total[TW-1:dad_pkg::FRAC_BITS];
    if (deg_w >= dad_pkg::DEG_FULL) begin
      angle_nxt = dad_pkg::DEG_MAX;
    end else begin
      angle_nxt = deg_w[dad_pkg::DEG_BITS-1:0];
    end
  end

  // stage valid bits and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v_r         <= {v_r[N-1:0], q_valid};
      out_valid_r <= v_r[N];
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (adv) begin
      x_r[0]   <= XW'(q_item.fx);
      y_r[0]   <= XW'(q_item.fy);
      z_r[0]   <= '0;
      cls_r[0] <= q_item.cls;
      dxn_r[0] <= q_item.dx_neg;
      dyn_r[0] <= q_item.dy_neg;
      for (int k = 0; k < N; k++) begin
        x_r[k+1]   <= x_nxt[k];
        y_r[k+1]   <= y_nxt[k];
        z_r[k+1]   <= z_nxt[k];
        cls_r[k+1] <= cls_r[k];
        dxn_r[k+1] <= dxn_r[k];
        dyn_r[k+1] <= dyn_r[k];
      end
      angle_r <= angle_nxt;
    end
  end

  `DAD_ASSERT(a_b_range, clk, rst_n, out_valid_r |-> angle_r <= dad_pkg::DEG_MAX, "angle out of range")
  `DAD_ASSERT(a_b_load, clk, rst_n, q_valid && adv |=> v_r[0], "popped transaction lost")
  `DAD_ASSERT(a_b_freeze, clk, rst_n, !adv |=> $stable(v_r), "pipe moved while held")
  `DAD_ASSERT(a_b_drain, clk, rst_n, v_r[N] && adv |=> out_valid_r, "last stage not delivered")

endmodule

>>> bench/displacement_angle_checker.sv
// result checker for the displacement angle unit: watches both channels,
// predicts each heading in fixed point and compares in order
// depends on nothing but the port widths of the unit
module displacement_angle_checker #(
  parameter int COORD_BITS = 12,
  parameter int ITERATIONS = 18
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [COORD_BITS-1:0] in_start_x,
  input  logic [COORD_BITS-1:0] in_start_y,
  input  logic [COORD_BITS-1:0] in_end_x,
  input  logic [COORD_BITS-1:0] in_end_y,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [8:0]            out_angle_deg,
  output int                    errors,
  output int                    pending,
  output int                    checked
);

  localparam longint ONE_DEG = 65536;
  localparam int     MAX_ROT = 24;

  // one predicted heading with the displacement that caused it
  typedef struct {
    logic [8:0] angle;
    longint     dx;
    longint     dy;
  } heading_t;

  heading_t heading_q[$];
  int       err_cnt = 0;
  int       cmp_cnt = 0;

  // arctangent of 2^-i in q.16 degrees, rounded
  function automatic longint rot_angle(input int i);
    longint v;
    case (i)
      0:  v = 2949120;
      1:  v = 1740967;
      2:  v = 919879;
      3:  v = 466945;
      4:  v = 234379;
      5:  v = 117304;
      6:  v = 58666;
      7:  v = 29335;
      8:  v = 14668;
      9:  v = 7334;
      10: v = 3667;
      11: v = 1833;
      12: v = 917;
      13: v = 458;
      14: v = 229;
      15: v = 115;
      16: v = 57;
      17: v = 29;
      18: v = 14;
      19: v = 7;
      20: v = 4;
      21: v = 2;
      22: v = 1;
      default: v = 0;
    endcase
    return v;
  endfunction

  // shift that truncates the magnitude, sign put back afterwards
  function automatic longint trunc_shift(input longint v, input int s);
    if (v >= 0)
      return v >>> s;
    return -((-v) >>> s);
  endfunction

  // vectoring rotation for 0 <= y < x, angle clamped to 0..45 degrees
  function automatic longint octant_rotate(input longint x_in, input longint y_in);
    longint x;
    longint y;
    longint z;
    longint xs;
    longint ys;
    x = x_in;
    y = y_in;
    z = 0;
    for (int i = 0; i < ITERATIONS && i < MAX_ROT; i++) begin
      xs = trunc_shift(x, i);
      ys = trunc_shift(y, i);
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + rot_angle(i);
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - rot_angle(i);
      end
    end
    if (z < 0)
      z = 0;
    if (z > 45 * ONE_DEG)
      z = 45 * ONE_DEG;
    return z;
  endfunction

  // whole-degree heading of the displacement, floored and saturated at 359
  function automatic logic [8:0] predict_heading(input longint dx, input longint dy);
    longint ax;
    longint ay;
    longint a;
    longint total;
    longint deg;
    int     scale;
    scale = 32 - COORD_BITS;
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    if (ax == 0 && ay == 0)
      return 9'd0;
    // first-quadrant angle
    if (ay == 0)
      a = 0;
    else if (ax == ay)
      a = 45 * ONE_DEG;
    else if (ay < ax)
      a = octant_rotate(ax <<< scale, ay <<< scale);
    else if (ax == 0)
      a = 90 * ONE_DEG;
    else
      a = 90 * ONE_DEG - octant_rotate(ay <<< scale, ax <<< scale);
    // rebuild by quadrant
    if (dx >= 0 && dy >= 0)
      total = a;
    else if (dx < 0 && dy >= 0)
      total = 180 * ONE_DEG - a;
    else if (dx < 0)
      total = 180 * ONE_DEG + a;
    else
      total = 360 * ONE_DEG - a;
    if (total < 0)
      total = 0;
    deg = total >>> 16;
    if (deg >= 360)
      deg = 359;
    return deg[8:0];
  endfunction

  // compare finished results first, then record the new transaction
  always @(posedge clk) begin
    heading_t exp_h;
    heading_t new_h;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (heading_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected result: expected nothing, got %0d", $time,
                   out_angle_deg);
        end else begin
          exp_h = heading_q.pop_front();
          cmp_cnt++;
          if (out_angle_deg !== exp_h.angle) begin
            err_cnt++;
            $display("%0t: angle mismatch for dx=%0d dy=%0d: expected %0d, got %0d",
                     $time, exp_h.dx, exp_h.dy, exp_h.angle, out_angle_deg);
          end
        end
      end
      if (in_valid && in_ready) begin
        new_h.dx    = longint'(in_end_x) - longint'(in_start_x);
        new_h.dy    = longint'(in_end_y) - longint'(in_start_y);
        new_h.angle = predict_heading(new_h.dx, new_h.dy);
        heading_q   = {heading_q, new_h};
      end
    end
    errors  <= err_cnt;
    pending <= heading_q.size();
    checked <= cmp_cnt;
  end

endmodule

>>> bench/testbench.sv
// top of the displacement angle bench: clock, reset, point-pair stimulus and verdict
// depends on dad_pkg, displacement_angle_degrees_unit and displacement_angle_checker
module testbench;

  localparam int CB        = dad_pkg::COORD_BITS_DEF;
  localparam int ITER      = dad_pkg::ITERATIONS_DEF;
  localparam int MAX_C     = (1 << CB) - 1;
  localparam int N_RANDOM  = 750;
  localparam int QUIET_AT  = 650;
  localparam int LIMIT     = 200000;
  localparam int DRAIN     = ITER + 12;

  logic          clk        = 1'b0;
  logic          rst_n      = 1'b0;
  logic          in_valid   = 1'b0;
  logic          in_ready;
  logic [CB-1:0] in_start_x = '0;
  logic [CB-1:0] in_start_y = '0;
  logic [CB-1:0] in_end_x   = '0;
  logic [CB-1:0] in_end_y   = '0;
  logic          out_valid;
  logic          out_ready  = 1'b0;
  logic [8:0]    out_angle_deg;

  int errors;
  int pending;
  int checked;
  int sent      = 0;
  int cycles    = 0;
  int hold_left = 0;
  bit quiet     = 1'b0;

  displacement_angle_degrees_unit dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_start_x   (in_start_x),
    .in_start_y   (in_start_y),
    .in_end_x     (in_end_x),
    .in_end_y     (in_end_y),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_angle_deg(out_angle_deg)
  );

  displacement_angle_checker #(
    .COORD_BITS(CB),
    .ITERATIONS(ITER)
  ) u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_start_x   (in_start_x),
    .in_start_y   (in_start_y),
    .in_end_x     (in_end_x),
    .in_end_y     (in_end_y),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_angle_deg(out_angle_deg),
    .errors       (errors),
    .pending      (pending),
    .checked      (checked)
  );

  // clock, period 10
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // cycle limit
  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // result side back-pressure in short bursts
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 4) == 0) begin
      hold_left = $urandom_range(1, 4) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // base + off when in range, otherwise base - off
  function automatic int offset_coord(input int base, input int off);
    if (base + off >= 0 && base + off <= MAX_C)
      return base + off;
    return base - off;
  endfunction

  // one transaction, with an optional idle burst ahead of it
  task automatic send_pair(input int sx, input int sy, input int ex, input int ey);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_start_x <= CB'(sx);
    in_start_y <= CB'(sy);
    in_end_x   <= CB'(ex);
    in_end_y   <= CB'(ey);
    @(negedge clk);
    while (!in_ready) begin
      @(posedge clk);
      @(negedge clk);
    end
    @(posedge clk);
    sent++;
  endtask

  initial begin
    int sx;
    int sy;
    int ex;
    int ey;
    int m;
    int kind;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // zero displacement, at the middle and at both corners
    send_pair(100, 100, 100, 100);
    send_pair(0, 0, 0, 0);
    send_pair(MAX_C, MAX_C, MAX_C, MAX_C);
    // axis directions at full length
    send_pair(0, 0, MAX_C, 0);
    send_pair(0, 0, 0, MAX_C);
    send_pair(MAX_C, 0, 0, 0);
    send_pair(0, MAX_C, 0, 0);
    // diagonals in all four quadrants
    send_pair(0, 0, MAX_C, MAX_C);
    send_pair(MAX_C, 0, 0, MAX_C);
    send_pair(MAX_C, MAX_C, 0, 0);
    send_pair(0, MAX_C, MAX_C, 0);
    // just below a full turn, where the result reads 359
    send_pair(0, 1, MAX_C, 0);
    send_pair(1, 1, MAX_C, 0);
    // either side of 180, 90 and 270
    send_pair(MAX_C, 0, 0, 1);
    send_pair(MAX_C, 1, 0, 0);
    send_pair(0, 0, 1, MAX_C);
    send_pair(1, 0, 0, MAX_C);
    send_pair(0, MAX_C, 1, 0);
    send_pair(1, MAX_C, 0, 0);
    // one step off the diagonal
    send_pair(0, 0, MAX_C, MAX_C - 1);
    send_pair(0, 0, MAX_C - 1, MAX_C);
    // unit steps
    send_pair(5, 5, 6, 5);
    send_pair(5, 5, 5, 4);
    // alternating bit patterns
    send_pair(12'hAAA, 12'h555, 12'h555, 12'hAAA);

    // random point pairs
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n >= QUIET_AT)
        quiet = 1'b1;
      kind = $urandom_range(0, 9);
      sx = $urandom_range(0, MAX_C);
      sy = $urandom_range(0, MAX_C);
      ex = $urandom_range(0, MAX_C);
      ey = $urandom_range(0, MAX_C);
      case (kind)
        5, 6: begin
          // short displacement
          ex = offset_coord(sx, $urandom_range(0, 16) - 8);
          ey = offset_coord(sy, $urandom_range(0, 16) - 8);
        end
        7: begin
          // axis or exact diagonal
          m = $urandom_range(0, 2047);
          case ($urandom_range(0, 2))
            0: begin
              ex = offset_coord(sx, $urandom_range(0, 1) ? m : -m);
              ey = sy;
            end
            1: begin
              ex = sx;
              ey = offset_coord(sy, $urandom_range(0, 1) ? m : -m);
            end
            default: begin
              ex = offset_coord(sx, $urandom_range(0, 1) ? m : -m);
              ey = offset_coord(sy, $urandom_range(0, 1) ? m : -m);
            end
          endcase
        end
        8: begin
          // magnitudes one apart, close to a diagonal
          m = $urandom_range(1, 2046);
          ex = offset_coord(sx, $urandom_range(0, 1) ? m : -m);
          m = m + ($urandom_range(0, 1) ? 1 : -1);
          ey = offset_coord(sy, $urandom_range(0, 1) ? m : -m);
        end
        9: begin
          // coordinates drawn from the range ends
          if ($urandom_range(0, 1)) sx = $urandom_range(0, 1) ? MAX_C : 0;
          if ($urandom_range(0, 1)) sy = $urandom_range(0, 1) ? MAX_C : 0;
          if ($urandom_range(0, 1)) ex = $urandom_range(0, 1) ? MAX_C : 0;
          if ($urandom_range(0, 1)) ey = $urandom_range(0, 1) ? MAX_C : 0;
        end
        default: ;
      endcase
      send_pair(sx, sy, ex, ey);
    end
    in_valid <= 1'b0;

    // drain the pipe, then allow for stray results
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("covered %0d point pairs: zero, axes, diagonals, wrap, extremes, random", sent);
    $display("compared %0d headings, %0d mismatches", checked, errors);
    if (errors == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
